[src/diff_drive_dual_pi_speed_control_defines.svh]
// Assertion macros for the differential-drive speed controller.
// Included by the top level; needs nothing else.
`ifndef DIFF_DRIVE_DUAL_PI_SPEED_CONTROL_DEFINES_SVH
`define DIFF_DRIVE_DUAL_PI_SPEED_CONTROL_DEFINES_SVH

// Same-cycle implication under synchronous reset.
`define DDPI_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication under synchronous reset.
`define DDPI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/ddpi_pkg.sv]
// Shared types, constants and the microprogram of the speed controller.
// Depends on nothing; every module imports it.
`default_nettype none

package ddpi_pkg;

  localparam int FRAC_BITS_DEF      = 16;
  localparam int PWM_FULL_SCALE_DEF = 1024;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam int OPND_W     = 33;
  localparam int PROD_W     = 2 * OPND_W;

  localparam logic [30:0] PROP_GAIN_RST        = 31'd524;
  localparam logic [30:0] INTEG_GAIN_RST       = 31'd1311;
  localparam logic [30:0] INTEGRAL_LIMIT_RST   = 31'd3276800;
  localparam logic [15:0] OUTPUT_LIMIT_RST     = 16'd32768;
  localparam logic [30:0] SPEED_TO_RPM_RST     = 31'd6327850;
  localparam logic [30:0] HALF_TRACK_RST       = 31'd9005;
  localparam logic [30:0] LEFT_COUNT_GAIN_RST  = 31'd68267;
  localparam logic [30:0] RIGHT_COUNT_GAIN_RST = 31'd136533;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_PROP_GAIN,
    REG_INTEG_GAIN,
    REG_INTEGRAL_LIMIT,
    REG_OUTPUT_LIMIT,
    REG_SPEED_TO_RPM,
    REG_HALF_TRACK,
    REG_LEFT_COUNT_GAIN,
    REG_RIGHT_COUNT_GAIN
  } cfg_index_t;

  typedef struct packed {
    logic signed [31:0] ref_forward_speed;
    logic signed [31:0] ref_turn_rate;
    logic [11:0]        left_hall_count;
    logic [11:0]        right_hall_count;
  } cmd_t;

  typedef struct packed {
    logic [10:0] left_duty;
    logic [10:0] right_duty;
    logic        left_clamped;
    logic        right_clamped;
  } result_t;

  typedef struct packed {
    logic [CFG_ADDR_W-1:0] reg_index;
    logic [CFG_DATA_W-1:0] reg_value;
  } cfg_write_t;

  typedef struct packed {
    logic [30:0] prop_gain;
    logic [30:0] integ_gain;
    logic [30:0] integral_limit;
    logic [15:0] output_limit;
    logic [30:0] speed_to_rpm;
    logic [30:0] half_track;
    logic [30:0] left_count_gain;
    logic [30:0] right_count_gain;
  } cfg_regs_t;

  typedef enum logic {WHEEL_LEFT, WHEEL_RIGHT} wheel_t;

  typedef enum logic [2:0] {
    MA_HALF_TRACK,
    MA_SPEED_TO_RPM,
    MA_LEFT_COUNT_GAIN,
    MA_RIGHT_COUNT_GAIN,
    MA_SAMPLE_TIME,
    MA_PROP_GAIN,
    MA_INTEG_GAIN,
    MA_PWM_SCALE
  } mul_a_sel_t;

  typedef enum logic [2:0] {
    MB_TURN,
    MB_T0,
    MB_T1,
    MB_T2,
    MB_LEFT_COUNT,
    MB_RIGHT_COUNT,
    MB_ERR,
    MB_INTEG
  } mul_b_sel_t;

  typedef enum logic [3:0] {
    ALU_NOP,
    ALU_SHSAT,
    ALU_SAT,
    ALU_ADD,
    ALU_SUB,
    ALU_INTEG,
    ALU_OUTP,
    ALU_OUTI,
    ALU_CLAMP,
    ALU_DUTY
  } alu_op_t;

  typedef enum logic [1:0] {X_FWD, X_T1, X_T2} x_sel_t;
  typedef enum logic {Y_T0, Y_T3} y_sel_t;
  typedef enum logic [1:0] {D_T0, D_T1, D_T2, D_T3} dst_t;
  typedef enum logic [1:0] {SQ_NEXT, SQ_LOOP, SQ_FINISH} seq_op_t;

  typedef struct packed {
    seq_op_t    seq_op;
    logic       mul_en;
    mul_a_sel_t mul_a;
    mul_b_sel_t mul_b;
    alu_op_t    alu_op;
    x_sel_t     x_sel;
    y_sel_t     y_sel;
    dst_t       dst;
    logic       neg;
  } ucode_t;

  typedef struct packed {
    logic   load;
    wheel_t wheel;
    ucode_t uc;
  } dp_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } seq_status_t;

  localparam int UCODE_LEN = 18;
  localparam int STEP_W    = $clog2(UCODE_LEN);
  localparam logic [STEP_W-1:0] STEP_WHEEL = STEP_W'(10);

  localparam ucode_t UCODE_NOP = '{
    seq_op: SQ_NEXT, mul_en: 1'b0, mul_a: MA_HALF_TRACK, mul_b: MB_TURN,
    alu_op: ALU_NOP, x_sel: X_FWD, y_sel: Y_T0, dst: D_T0, neg: 1'b0
  };

  // Steps before STEP_WHEEL form the kinematics and the errors of both wheels.
  // The wheel routine then runs once per wheel, the loop step switching wheels.
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    w = UCODE_NOP;
    unique case (step)
      STEP_W'(0): begin
        w.mul_en = 1'b1; w.mul_a = MA_HALF_TRACK; w.mul_b = MB_TURN;
      end
      STEP_W'(1): begin
        w.alu_op = ALU_SHSAT; w.dst = D_T0;
      end
      STEP_W'(2): begin
        w.alu_op = ALU_SUB; w.x_sel = X_FWD; w.y_sel = Y_T0; w.dst = D_T1;
      end
      STEP_W'(3): begin
        w.alu_op = ALU_ADD; w.x_sel = X_FWD; w.y_sel = Y_T0; w.dst = D_T2;
        w.mul_en = 1'b1; w.mul_a = MA_SPEED_TO_RPM; w.mul_b = MB_T1;
      end
      STEP_W'(4): begin
        w.alu_op = ALU_SHSAT; w.neg = 1'b1; w.dst = D_T1;
        w.mul_en = 1'b1; w.mul_a = MA_SPEED_TO_RPM; w.mul_b = MB_T2;
      end
      STEP_W'(5): begin
        w.alu_op = ALU_SHSAT; w.dst = D_T2;
        w.mul_en = 1'b1; w.mul_a = MA_LEFT_COUNT_GAIN; w.mul_b = MB_LEFT_COUNT;
      end
      STEP_W'(6): begin
        w.alu_op = ALU_SAT; w.dst = D_T3;
        w.mul_en = 1'b1; w.mul_a = MA_RIGHT_COUNT_GAIN; w.mul_b = MB_RIGHT_COUNT;
      end
      STEP_W'(7): begin
        w.alu_op = ALU_SAT; w.dst = D_T0;
      end
      STEP_W'(8): begin
        w.alu_op = ALU_SUB; w.x_sel = X_T1; w.y_sel = Y_T3; w.dst = D_T1;
      end
      STEP_W'(9): begin
        w.alu_op = ALU_SUB; w.x_sel = X_T2; w.y_sel = Y_T0; w.dst = D_T2;
      end
      STEP_W'(10): begin
        w.mul_en = 1'b1; w.mul_a = MA_SAMPLE_TIME; w.mul_b = MB_ERR;
      end
      STEP_W'(11): begin
        w.alu_op = ALU_INTEG;
        w.mul_en = 1'b1; w.mul_a = MA_PROP_GAIN; w.mul_b = MB_ERR;
      end
      STEP_W'(12): begin
        w.alu_op = ALU_OUTP;
        w.mul_en = 1'b1; w.mul_a = MA_INTEG_GAIN; w.mul_b = MB_INTEG;
      end
      STEP_W'(13): begin
        w.alu_op = ALU_OUTI;
      end
      STEP_W'(14): begin
        w.alu_op = ALU_CLAMP; w.dst = D_T0;
      end
      STEP_W'(15): begin
        w.mul_en = 1'b1; w.mul_a = MA_PWM_SCALE; w.mul_b = MB_T0;
      end
      STEP_W'(16): begin
        w.alu_op = ALU_DUTY; w.seq_op = SQ_LOOP;
      end
      STEP_W'(17): begin
        w.seq_op = SQ_FINISH;
      end
      default: begin
        w.seq_op = SQ_FINISH;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

[src/ddpi_stream_if.sv]
// Valid/ready channel that carries one word of a given payload type.
// Depends on nothing; the payload type comes from the instantiating level.
`default_nettype none

interface ddpi_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[src/ddpi_cfg_regs.sv]
// Configuration register bank of the speed controller.
// Depends on ddpi_pkg and ddpi_stream_if.
`default_nettype none

module ddpi_cfg_regs (
  input  logic                clk,
  input  logic                rst,
  ddpi_stream_if.sink         cfg,
  output ddpi_pkg::cfg_regs_t regs
);
  import ddpi_pkg::*;

  logic [30:0] v31;

  assign cfg.ready = 1'b1;
  assign v31       = cfg.data.reg_value[30:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.prop_gain        <= PROP_GAIN_RST;
      regs.integ_gain       <= INTEG_GAIN_RST;
      regs.integral_limit   <= INTEGRAL_LIMIT_RST;
      regs.output_limit     <= OUTPUT_LIMIT_RST;
      regs.speed_to_rpm     <= SPEED_TO_RPM_RST;
      regs.half_track       <= HALF_TRACK_RST;
      regs.left_count_gain  <= LEFT_COUNT_GAIN_RST;
      regs.right_count_gain <= RIGHT_COUNT_GAIN_RST;
    end else if (cfg.valid) begin
      unique case (cfg.data.reg_index)
        REG_PROP_GAIN:        regs.prop_gain        <= v31;
        REG_INTEG_GAIN:       regs.integ_gain       <= v31;
        REG_INTEGRAL_LIMIT:   regs.integral_limit   <= v31;
        REG_OUTPUT_LIMIT:     regs.output_limit     <= cfg.data.reg_value[15:0];
        REG_SPEED_TO_RPM:     regs.speed_to_rpm     <= v31;
        REG_HALF_TRACK:       regs.half_track       <= v31;
        REG_LEFT_COUNT_GAIN:  regs.left_count_gain  <= v31;
        REG_RIGHT_COUNT_GAIN: regs.right_count_gain <= v31;
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[src/ddpi_sequencer.sv]
// Microcode sequencer: step counter, wheel select and the control ROM.
// Depends on ddpi_pkg.
`default_nettype none

module ddpi_sequencer (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  out_free,
  output ddpi_pkg::dp_ctrl_t    ctrl,
  output ddpi_pkg::seq_status_t status
);
  import ddpi_pkg::*;

  logic              busy;
  logic [STEP_W-1:0] step;
  wheel_t            wheel;
  ucode_t            word;

  assign word          = busy ? ucode_rom(step) : UCODE_NOP;
  assign ctrl.load     = start;
  assign ctrl.wheel    = wheel;
  assign ctrl.uc       = word;
  assign status.busy   = busy;
  assign status.done   = busy && (word.seq_op == SQ_FINISH) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      step  <= '0;
      wheel <= WHEEL_LEFT;
    end else if (start) begin
      busy  <= 1'b1;
      step  <= '0;
      wheel <= WHEEL_LEFT;
    end else if (busy) begin
      unique case (word.seq_op)
        SQ_NEXT: step <= step + 1'b1;
        SQ_LOOP: begin
          if (wheel == WHEEL_LEFT) begin
            wheel <= WHEEL_RIGHT;
            step  <= STEP_WHEEL;
          end else begin
            step <= step + 1'b1;
          end
        end
        SQ_FINISH: begin
          if (out_free) begin
            busy <= 1'b0;
          end
        end
        default: busy <= 1'b0;
      endcase
    end
  end

endmodule

`default_nettype wire

[src/ddpi_datapath.sv]
// Datapath: operand registers, one shared multiplier and a saturating ALU.
// Depends on ddpi_pkg; driven word by word from ddpi_sequencer.
`default_nettype none

module ddpi_datapath #(
  parameter int FRAC_BITS      = ddpi_pkg::FRAC_BITS_DEF,
  parameter int PWM_FULL_SCALE = ddpi_pkg::PWM_FULL_SCALE_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  ddpi_pkg::dp_ctrl_t  ctrl,
  input  ddpi_pkg::cmd_t      cmd_word,
  input  ddpi_pkg::cfg_regs_t regs,
  output ddpi_pkg::result_t   res
);
  import ddpi_pkg::*;

  localparam int ACC_W    = PROD_W - FRAC_BITS + 1;
  localparam int ACCX_W   = ACC_W + 1;
  localparam int SAT_IN_W = PROD_W + 2;
  localparam logic signed [OPND_W-1:0] SAMPLE_TIME =
    OPND_W'(((1 << FRAC_BITS) + 50) / 100);
  localparam logic signed [OPND_W-1:0] PWM_SCALE = OPND_W'(PWM_FULL_SCALE);
  localparam logic signed [ACCX_W-1:0] HALF_Q = ACCX_W'(64'sd1 <<< (FRAC_BITS - 1));
  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  function automatic logic signed [31:0] sat32(input logic signed [SAT_IN_W-1:0] x);
    if ((x[SAT_IN_W-1:31] == '0) || (x[SAT_IN_W-1:31] == '1)) begin
      return x[31:0];
    end else if (x[SAT_IN_W-1]) begin
      return S32_MIN;
    end
    return S32_MAX;
  endfunction

  logic signed [31:0]        fwd, turn;
  logic [11:0]               lcount, rcount;
  logic signed [31:0]        t0, t1, t2, t3;
  logic signed [31:0]        integ_l, integ_r;
  logic signed [ACC_W-1:0]   acc;
  logic signed [PROD_W-1:0]  prod;
  logic                      flag_l, flag_r;
  logic [10:0]               duty_l, duty_r;

  logic signed [OPND_W-1:0]  opa, opb;
  logic signed [31:0]        err_sel, integ_sel;
  logic signed [PROD_W-1:0]  sh;
  logic signed [PROD_W:0]    sh_neg;
  logic signed [32:0]        xv, yv, addsub;
  logic signed [33:0]        integ_sum, lim_i, integ_new;
  logic signed [ACCX_W-1:0]  out_v, ol, lim_o, out_c;
  logic                      out_hit;
  logic                      t_we;
  logic signed [31:0]        t_val;
  logic [10:0]               duty_v;

  assign err_sel   = (ctrl.wheel == WHEEL_LEFT) ? t1 : t2;
  assign integ_sel = (ctrl.wheel == WHEEL_LEFT) ? integ_l : integ_r;

  always_comb begin
    unique case (ctrl.uc.mul_a)
      MA_HALF_TRACK:       opa = OPND_W'(regs.half_track);
      MA_SPEED_TO_RPM:     opa = OPND_W'(regs.speed_to_rpm);
      MA_LEFT_COUNT_GAIN:  opa = OPND_W'(regs.left_count_gain);
      MA_RIGHT_COUNT_GAIN: opa = OPND_W'(regs.right_count_gain);
      MA_SAMPLE_TIME:      opa = SAMPLE_TIME;
      MA_PROP_GAIN:        opa = OPND_W'(regs.prop_gain);
      MA_INTEG_GAIN:       opa = OPND_W'(regs.integ_gain);
      MA_PWM_SCALE:        opa = PWM_SCALE;
      default:             opa = '0;
    endcase
    unique case (ctrl.uc.mul_b)
      MB_TURN:        opb = OPND_W'(turn);
      MB_T0:          opb = OPND_W'(t0);
      MB_T1:          opb = OPND_W'(t1);
      MB_T2:          opb = OPND_W'(t2);
      MB_LEFT_COUNT:  opb = OPND_W'(lcount);
      MB_RIGHT_COUNT: opb = OPND_W'(rcount);
      MB_ERR:         opb = OPND_W'(err_sel);
      MB_INTEG:       opb = OPND_W'(integ_sel);
      default:        opb = '0;
    endcase
  end

  always_comb begin
    sh     = prod >>> FRAC_BITS;
    sh_neg = ctrl.uc.neg ? -(PROD_W + 1)'(sh) : (PROD_W + 1)'(sh);

    unique case (ctrl.uc.x_sel)
      X_FWD:   xv = 33'(fwd);
      X_T1:    xv = 33'(t1);
      X_T2:    xv = 33'(t2);
      default: xv = 33'(fwd);
    endcase
    unique case (ctrl.uc.y_sel)
      Y_T0: yv = 33'(t0);
      Y_T3: yv = 33'(t3);
      default: yv = 33'(t0);
    endcase
    addsub = (ctrl.uc.alu_op == ALU_SUB) ? (xv - yv) : (xv + yv);

    integ_sum = 34'(integ_sel) + $signed(sh[33:0]);
    lim_i     = 34'(regs.integral_limit);
    if (integ_sum > lim_i) begin
      integ_new = lim_i;
    end else if (integ_sum < -lim_i) begin
      integ_new = -lim_i;
    end else begin
      integ_new = integ_sum;
    end

    out_v = (ctrl.wheel == WHEEL_LEFT) ? -ACCX_W'(acc) : ACCX_W'(acc);
    ol    = ACCX_W'(regs.output_limit);
    lim_o = (ol > HALF_Q) ? HALF_Q : ol;
    if (out_v > lim_o) begin
      out_c   = lim_o;
      out_hit = 1'b1;
    end else if (out_v < -lim_o) begin
      out_c   = -lim_o;
      out_hit = 1'b1;
    end else begin
      out_c   = out_v;
      out_hit = 1'b0;
    end

    duty_v = prod[FRAC_BITS +: 11];

    unique case (ctrl.uc.alu_op)
      ALU_SHSAT: begin
        t_we  = 1'b1;
        t_val = sat32(SAT_IN_W'(sh_neg));
      end
      ALU_SAT: begin
        t_we  = 1'b1;
        t_val = sat32(SAT_IN_W'(prod));
      end
      ALU_ADD, ALU_SUB: begin
        t_we  = 1'b1;
        t_val = sat32(SAT_IN_W'(addsub));
      end
      ALU_CLAMP: begin
        t_we  = 1'b1;
        t_val = 32'(HALF_Q + out_c);
      end
      default: begin
        t_we  = 1'b0;
        t_val = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      fwd    <= cmd_word.ref_forward_speed;
      turn   <= cmd_word.ref_turn_rate;
      lcount <= cmd_word.left_hall_count;
      rcount <= cmd_word.right_hall_count;
    end
    if (ctrl.uc.mul_en) begin
      prod <= opa * opb;
    end
    if (t_we) begin
      unique case (ctrl.uc.dst)
        D_T0: t0 <= t_val;
        D_T1: t1 <= t_val;
        D_T2: t2 <= t_val;
        D_T3: t3 <= t_val;
        default: t0 <= t_val;
      endcase
    end
    unique case (ctrl.uc.alu_op)
      ALU_OUTP: acc <= $signed(sh[ACC_W-1:0]);
      ALU_OUTI: acc <= acc + $signed(sh[ACC_W-1:0]);
      ALU_CLAMP: begin
        if (ctrl.wheel == WHEEL_LEFT) begin
          flag_l <= out_hit;
        end else begin
          flag_r <= out_hit;
        end
      end
      ALU_DUTY: begin
        if (ctrl.wheel == WHEEL_LEFT) begin
          duty_l <= duty_v;
        end else begin
          duty_r <= duty_v;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integ_l <= '0;
      integ_r <= '0;
    end else if (ctrl.uc.alu_op == ALU_INTEG) begin
      if (ctrl.wheel == WHEEL_LEFT) begin
        integ_l <= integ_new[31:0];
      end else begin
        integ_r <= integ_new[31:0];
      end
    end
  end

  assign res.left_duty     = duty_l;
  assign res.right_duty    = duty_r;
  assign res.left_clamped  = flag_l;
  assign res.right_clamped = flag_r;

endmodule

`default_nettype wire

[src/diff_drive_dual_pi_speed_control.sv]
// Channel   Dir  Payload        Notes
// cmd       in   cmd_t          speed, turn rate and Hall counts, one word per tick
// cfg       in   cfg_write_t    register index and value, always ready
// result    out  result_t       duties and clamp flags, held in an output register
//
// The handling of a word runs through the acceptance cycle, ten program steps of
// kinematics, seven steps of the wheel routine for each wheel and one hand-off step.
// A new word is accepted only after the hand-off step. The steps run in sequence because
// the single 33 by 33 bit multiplier is shared by all products. Reset clears the sequencer,
// both integrators and the result valid flag, and loads the default gains. The hand-off
// step waits while the result register still holds a word.
`default_nettype none
`include "diff_drive_dual_pi_speed_control_defines.svh"

module diff_drive_dual_pi_speed_control #(
  parameter int FRAC_BITS      = ddpi_pkg::FRAC_BITS_DEF,
  parameter int PWM_FULL_SCALE = ddpi_pkg::PWM_FULL_SCALE_DEF
) (
  input  logic           clk,
  input  logic           rst,
  ddpi_stream_if.sink    cmd,
  ddpi_stream_if.sink    cfg,
  ddpi_stream_if.source  result
);
  import ddpi_pkg::*;

  seq_status_t status;
  dp_ctrl_t    ctrl;
  cfg_regs_t   regs;
  result_t     dp_res;
  logic        start;
  logic        out_free;

  assign cmd.ready = !status.busy;
  assign start     = cmd.valid && cmd.ready;
  assign out_free  = !result.valid || result.ready;

  ddpi_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  ddpi_sequencer u_sequencer (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .out_free (out_free),
    .ctrl     (ctrl),
    .status   (status)
  );

  ddpi_datapath #(
    .FRAC_BITS      (FRAC_BITS),
    .PWM_FULL_SCALE (PWM_FULL_SCALE)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .cmd_word (cmd.data),
    .regs     (regs),
    .res      (dp_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (status.done) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
    if (status.done) begin
      result.data <= dp_res;
    end
  end

  `DDPI_ASSERT_NEXT(a_accept_starts_work, clk, rst, cmd.valid && cmd.ready, status.busy, "accepted word did not start the program")
  `DDPI_ASSERT_NOW(a_done_needs_room, clk, rst, status.done, !result.valid || result.ready, "result produced into a full register")
  `DDPI_ASSERT_NOW(a_result_from_program, clk, rst, $rose(result.valid), $past(status.done), "result word appeared without a finished program")

endmodule

`default_nettype wire
